FILE: src/alpag_pkg.sv
// Shared constants, types and tables for the polar angle gap pipeline.
package alpag_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int SQRT_STEPS        = 31;
    localparam int PRESCALE_SHIFT    = 20;

    localparam logic signed [35:0] PI_Q28      = 36'sd843314857;
    localparam logic signed [35:0] HALF_PI_Q28 = 36'sd421657428;
    localparam logic signed [35:0] TWO_PI_Q28  = 36'sd1686629713;

    localparam logic [1:0] ST_FOUND       = 2'd0;
    localparam logic [1:0] ST_OUT_OF_BAND = 2'd1;
    localparam logic [1:0] ST_OFF_SEGMENT = 2'd2;

    localparam logic [2:0] REG_LINE_OFFSET  = 3'd0;
    localparam logic [2:0] REG_SEGMENT_LOW  = 3'd1;
    localparam logic [2:0] REG_SEGMENT_HIGH = 3'd2;
    localparam logic [2:0] REG_AXIS_SELECT  = 3'd3;
    localparam logic [2:0] REG_RADIUS_LOW   = 3'd4;
    localparam logic [2:0] REG_RADIUS_HIGH  = 3'd5;

    typedef struct packed {
        logic signed [31:0] qa;
        logic               lower;
        logic               special;
        logic               oob;
        logic [30:0]        r;
        logic signed [31:0] mc;
        logic [31:0]        h;
    } t_side;

    // atan(2^-i) in Q2.30
    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] v;
        begin
            case (i)
                0:  v = 34'sh3243F6A8;
                1:  v = 34'sh1DAC6705;
                2:  v = 34'sh0FADBAFC;
                3:  v = 34'sh07F56EA6;
                4:  v = 34'sh03FEAB76;
                5:  v = 34'sh01FFD55B;
                6:  v = 34'sh00FFFAAA;
                7:  v = 34'sh007FFF55;
                8:  v = 34'sh003FFFEA;
                9:  v = 34'sh001FFFFD;
                10: v = 34'sh000FFFFF;
                11: v = 34'sh0007FFFF;
                12: v = 34'sh0003FFFF;
                13: v = 34'sh0001FFFF;
                14: v = 34'sh0000FFFF;
                15: v = 34'sh00007FFF;
                16: v = 34'sh00003FFF;
                17: v = 34'sh00001FFF;
                18: v = 34'sh00000FFF;
                19: v = 34'sh000007FF;
                20: v = 34'sh000003FF;
                21: v = 34'sh000001FF;
                22: v = 34'sh000000FF;
                23: v = 34'sh0000007F;
                24: v = 34'sh0000003F;
                25: v = 34'sh0000001F;
                26: v = 34'sh0000000F;
                27: v = 34'sh00000008;
                28: v = 34'sh00000004;
                29: v = 34'sh00000002;
                30: v = 34'sh00000001;
                default: v = 34'sh0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: src/axis_line_polar_angle_gap.sv
// Polar angle gap to one axis-aligned line segment: band check, isqrt, CORDIC, wrap.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one query per transfer:
//   radius (Q16.16), angle (Q4.28) and the lower/upper crossing choice.
//   Output channel (o_out_valid / i_out_ready) returns one result per query,
//   in order: wrapped angle gap (Q4.28) and a status code.
//   The segment, line offset, axis and radius band come in through the write
//   port (i_cfg_wr_en, i_cfg_addr, i_cfg_wr_data); write them while idle.
// Throughput: one query per cycle while the output is not stalled (see Stall).
// Pipeline depth is set mostly by the bit-per-stage square root (31 stages)
//   and the CORDIC (24 stages).
// Reset (i_rst_n low, synchronous) empties the pipeline and clears all
//   configuration registers to zero.
// Stall: when a result waits and i_out_ready is low, the whole pipeline
//   holds and o_in_ready drops; nothing is lost or repeated.
module axis_line_polar_angle_gap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [30:0] i_query_radius,
    input  logic signed [31:0] i_query_angle,
    input  logic        i_use_lower_crossing,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [30:0] o_angle_gap,
    output logic [1:0]  o_status
);
    import alpag_pkg::*;

    logic signed [31:0] r_line_offset;
    logic signed [31:0] r_segment_low;
    logic signed [31:0] r_segment_high;
    logic               r_axis_select;
    logic [30:0]        r_radius_low;
    logic [30:0]        r_radius_high;

    logic w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_offset  <= '0;
            r_segment_low  <= '0;
            r_segment_high <= '0;
            r_axis_select  <= 1'b0;
            r_radius_low   <= '0;
            r_radius_high  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_LINE_OFFSET:  r_line_offset  <= i_cfg_wr_data;
                REG_SEGMENT_LOW:  r_segment_low  <= i_cfg_wr_data;
                REG_SEGMENT_HIGH: r_segment_high <= i_cfg_wr_data;
                REG_AXIS_SELECT:  r_axis_select  <= i_cfg_wr_data[0];
                REG_RADIUS_LOW:   r_radius_low   <= i_cfg_wr_data[30:0];
                REG_RADIUS_HIGH:  r_radius_high  <= i_cfg_wr_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: band check, clamp ----------------
    logic        r_s1_vld;
    t_side       r_s1_side;
    logic [30:0] r_s1_mabs;

    logic signed [32:0] w_r33;
    logic signed [32:0] w_m33;
    logic signed [31:0] n_mc;
    t_side              n_s1_side;

    always_comb begin
        w_r33 = {2'b00, i_query_radius};
        w_m33 = {r_line_offset[31], r_line_offset};
        if (w_m33 > w_r33) begin
            n_mc = w_r33[31:0];
        end else if (w_m33 < -w_r33) begin
            n_mc = 32'(-w_r33);
        end else begin
            n_mc = r_line_offset;
        end
        n_s1_side.qa      = i_query_angle;
        n_s1_side.lower   = i_use_lower_crossing;
        n_s1_side.special = (i_query_radius == '0) || (r_line_offset == '0);
        n_s1_side.oob     = (i_query_radius < r_radius_low) ||
                            (i_query_radius > r_radius_high);
        n_s1_side.r       = i_query_radius;
        n_s1_side.mc      = n_mc;
        n_s1_side.h       = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_in_valid;
        end
        if (w_adv) begin
            r_s1_side <= n_s1_side;
            r_s1_mabs <= n_mc[31] ? 31'(-n_mc) : n_mc[30:0];
        end
    end

    // ---------------- stage 2: squares ----------------
    logic        r_s2_vld;
    t_side       r_s2_side;
    logic [61:0] r_s2_rr;
    logic [61:0] r_s2_mm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s2_vld <= r_s1_vld;
        end
        if (w_adv) begin
            r_s2_side <= r_s1_side;
            r_s2_rr   <= 62'(r_s1_side.r) * 62'(r_s1_side.r);
            r_s2_mm   <= 62'(r_s1_mabs) * 62'(r_s1_mabs);
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic        r_sq_vld  [0:SQRT_STEPS];
    t_side       r_sq_side [0:SQRT_STEPS];
    logic [61:0] r_sq_val  [0:SQRT_STEPS];
    logic [61:0] r_sq_res  [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_sq_vld[0] <= r_s2_vld;
        end
        if (w_adv) begin
            r_sq_side[0] <= r_s2_side;
            r_sq_val[0]  <= r_s2_rr - r_s2_mm;
            r_sq_res[0]  <= '0;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [61:0] BIT = 62'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [61:0] n_val;
        logic [61:0] n_res;
        logic [61:0] w_rb;

        always_comb begin
            w_rb = r_sq_res[k] + BIT;
            if (r_sq_val[k] >= w_rb) begin
                n_val = r_sq_val[k] - w_rb;
                n_res = (r_sq_res[k] >> 1) + BIT;
            end else begin
                n_val = r_sq_val[k];
                n_res = r_sq_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
            if (w_adv) begin
                r_sq_side[k+1] <= r_sq_side[k];
                r_sq_val[k+1]  <= n_val;
                r_sq_res[k+1]  <= n_res;
            end
        end
    end

    // ---------------- CORDIC vectoring, atan2(mc, h) ----------------
    logic               r_cd_vld  [0:CORDIC_ITERATIONS];
    t_side              r_cd_side [0:CORDIC_ITERATIONS];
    logic signed [55:0] r_cd_x    [0:CORDIC_ITERATIONS];
    logic signed [55:0] r_cd_y    [0:CORDIC_ITERATIONS];
    logic signed [33:0] r_cd_z    [0:CORDIC_ITERATIONS];

    t_side       n_cd0_side;
    logic [31:0] w_h;

    always_comb begin
        w_h          = r_sq_res[SQRT_STEPS][31:0];
        n_cd0_side   = r_sq_side[SQRT_STEPS];
        n_cd0_side.h = w_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_cd_vld[0] <= r_sq_vld[SQRT_STEPS];
        end
        if (w_adv) begin
            r_cd_side[0] <= n_cd0_side;
            r_cd_x[0]    <= signed'(56'(w_h)) <<< PRESCALE_SHIFT;
            r_cd_y[0]    <= 56'(n_cd0_side.mc) <<< PRESCALE_SHIFT;
            r_cd_z[0]    <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cordic
        logic signed [55:0] w_dx;
        logic signed [55:0] w_dy;
        logic signed [55:0] n_x;
        logic signed [55:0] n_y;
        logic signed [33:0] n_z;

        always_comb begin
            w_dx = r_cd_y[i] >>> i;
            w_dy = r_cd_x[i] >>> i;
            if (r_cd_y[i] > 0) begin
                n_x = r_cd_x[i] + w_dx;
                n_y = r_cd_y[i] - w_dy;
                n_z = r_cd_z[i] + atan_q30(i);
            end else begin
                n_x = r_cd_x[i] - w_dx;
                n_y = r_cd_y[i] + w_dy;
                n_z = r_cd_z[i] - atan_q30(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cd_vld[i+1] <= 1'b0;
            end else if (w_adv) begin
                r_cd_vld[i+1] <= r_cd_vld[i];
            end
            if (w_adv) begin
                r_cd_side[i+1] <= r_cd_side[i];
                r_cd_x[i+1]    <= n_x;
                r_cd_y[i+1]    <= n_y;
                r_cd_z[i+1]    <= n_z;
            end
        end
    end

    // ---------------- F1: crossing angle and along-line coordinate ----------------
    logic               r_f1_vld;
    t_side              r_f1_side;
    logic signed [35:0] r_f1_phi;
    logic signed [32:0] r_f1_s;

    t_side              w_cs;
    logic signed [33:0] w_za;
    logic signed [35:0] w_a;
    logic signed [35:0] w_t;
    logic signed [32:0] w_hs;
    logic signed [35:0] n_phi;
    logic signed [32:0] n_s;

    always_comb begin
        w_cs = r_cd_side[CORDIC_ITERATIONS];
        w_za = r_cd_z[CORDIC_ITERATIONS] + 34'sd2;
        w_a  = 36'(w_za >>> 2);
        w_t  = HALF_PI_Q28 - w_a;
        w_hs = signed'({1'b0, w_cs.h});
        if (w_cs.special) begin
            n_phi = r_axis_select ? HALF_PI_Q28 : '0;
            n_s   = signed'({2'b00, w_cs.r});
        end else if (r_axis_select) begin
            n_phi = w_cs.lower ? -w_t : w_t;
            n_s   = w_cs.lower ? -w_hs : w_hs;
        end else if (!r_line_offset[31]) begin
            n_phi = w_cs.lower ? w_a : PI_Q28 - w_a;
            n_s   = w_cs.lower ? w_hs : -w_hs;
        end else begin
            n_phi = w_cs.lower ? -PI_Q28 - w_a : w_a;
            n_s   = w_cs.lower ? -w_hs : w_hs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else if (w_adv) begin
            r_f1_vld <= r_cd_vld[CORDIC_ITERATIONS];
        end
        if (w_adv) begin
            r_f1_side <= w_cs;
            r_f1_phi  <= n_phi;
            r_f1_s    <= n_s;
        end
    end

    // ---------------- F2: segment check, raw difference biased positive ----------------
    logic               r_f2_vld;
    logic [1:0]         r_f2_status;
    logic signed [35:0] r_f2_d;

    logic [1:0] n_f2_status;

    always_comb begin
        if (r_f1_side.oob) begin
            n_f2_status = ST_OUT_OF_BAND;
        end else if (r_f1_s < 33'(r_segment_low) || r_f1_s > 33'(r_segment_high)) begin
            n_f2_status = ST_OFF_SEGMENT;
        end else begin
            n_f2_status = ST_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_vld <= 1'b0;
        end else if (w_adv) begin
            r_f2_vld <= r_f1_vld;
        end
        if (w_adv) begin
            r_f2_status <= n_f2_status;
            r_f2_d      <= 36'(r_f1_side.qa) - r_f1_phi + 3 * TWO_PI_Q28;
        end
    end

    // ---------------- F3..F5: reduce into [0, 2pi) ----------------
    logic               r_f3_vld;
    logic [1:0]         r_f3_status;
    logic signed [35:0] r_f3_d;
    logic               r_f4_vld;
    logic [1:0]         r_f4_status;
    logic signed [35:0] r_f4_d;
    logic               r_f5_vld;
    logic [1:0]         r_f5_status;
    logic [30:0]        r_f5_gap;

    logic signed [35:0] n_f5_d;

    always_comb begin
        n_f5_d = (r_f4_d >= TWO_PI_Q28) ? r_f4_d - TWO_PI_Q28 : r_f4_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_vld <= 1'b0;
            r_f4_vld <= 1'b0;
            r_f5_vld <= 1'b0;
        end else if (w_adv) begin
            r_f3_vld <= r_f2_vld;
            r_f4_vld <= r_f3_vld;
            r_f5_vld <= r_f4_vld;
        end
        if (w_adv) begin
            r_f3_status <= r_f2_status;
            r_f3_d      <= (r_f2_d >= 4 * TWO_PI_Q28) ? r_f2_d - 4 * TWO_PI_Q28 : r_f2_d;
            r_f4_status <= r_f3_status;
            r_f4_d      <= (r_f3_d >= 2 * TWO_PI_Q28) ? r_f3_d - 2 * TWO_PI_Q28 : r_f3_d;
            r_f5_status <= r_f4_status;
            r_f5_gap    <= (r_f4_status == ST_FOUND) ? n_f5_d[30:0] : '0;
        end
    end

    // pipeline moves whenever the output slot is free or being drained
    assign w_adv       = !r_f5_vld || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_f5_vld;
    assign o_angle_gap = r_f5_gap;
    assign o_status    = r_f5_status;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_FOUND || o_status == ST_OUT_OF_BAND ||
                         o_status == ST_OFF_SEGMENT))
        else $error("bad status code");

    a_gap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_FOUND) |-> (o_angle_gap == '0))
        else $error("gap not zero on failed query");

    a_gap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (36'(o_angle_gap) < TWO_PI_Q28))
        else $error("gap not wrapped");

endmodule

FILE: verif/alpag_checker.sv
// Checker for the polar angle gap block: predicts each result and compares it.
`timescale 1ns / 1ps
module alpag_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [30:0] i_query_radius,
    input  logic [31:0] i_query_angle,
    input  logic        i_use_lower_crossing,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [30:0] i_angle_gap,
    input  logic [1:0]  i_status,
    output int          o_fail_count,
    output int          o_pending
);
    import alpag_pkg::*;

    typedef struct packed {
        logic [30:0] gap;
        logic [1:0]  status;
    } t_gap_result;

    logic signed [31:0] offset_q;
    logic signed [31:0] seg_lo_q;
    logic signed [31:0] seg_hi_q;
    logic               axis_x;
    logic [30:0]        band_lo_q;
    logic [30:0]        band_hi_q;

    t_gap_result gap_queue[$];

    assign o_pending = gap_queue.size();

    // atan2(y, x) for x >= 0, vectoring rotation, Q4.28 result
    function automatic longint cordic_angle(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        x = x <<< PRESCALE_SHIFT;
        y = y <<< PRESCALE_SHIFT;
        for (int i = 0; i < CORDIC_ITERATIONS && i < 31; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_q30(i));
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_q30(i));
            end
        end
        return (z + 2) >>> 2;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic t_gap_result predict_gap(logic [30:0] radius, logic [31:0] angle,
                                                logic lower);
        t_gap_result res;
        longint r;
        longint qa;
        longint m;
        longint mc;
        longint h;
        longint a;
        longint t;
        longint phi;
        longint s;
        longint g;
        r = longint'(radius);
        qa = longint'($signed(angle));
        m = longint'(offset_q);
        res = '0;
        if (radius < band_lo_q || radius > band_hi_q) begin
            res.status = ST_OUT_OF_BAND;
            return res;
        end
        if (r == 0 || m == 0) begin
            phi = axis_x ? longint'(HALF_PI_Q28) : 0;
            s = r;
        end else begin
            mc = m > r ? r : (m < -r ? -r : m);
            h = floor_sqrt(longint'(r * r - mc * mc));
            a = cordic_angle(mc, h);
            if (axis_x) begin
                t = longint'(HALF_PI_Q28) - a;
                phi = lower ? -t : t;
                s = lower ? -h : h;
            end else if (m > 0) begin
                phi = lower ? a : longint'(PI_Q28) - a;
                s = lower ? h : -h;
            end else begin
                phi = lower ? -longint'(PI_Q28) - a : a;
                s = lower ? -h : h;
            end
        end
        if (s < longint'(seg_lo_q) || s > longint'(seg_hi_q)) begin
            res.status = ST_OFF_SEGMENT;
            return res;
        end
        g = (qa - phi) % longint'(TWO_PI_Q28);
        if (g < 0) g = g + longint'(TWO_PI_Q28);
        res.gap = g[30:0];
        res.status = ST_FOUND;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_gap_result exp_res;
        if (!i_rst_n) begin
            offset_q  <= '0;
            seg_lo_q  <= '0;
            seg_hi_q  <= '0;
            axis_x    <= 1'b0;
            band_lo_q <= '0;
            band_hi_q <= '0;
            o_fail_count <= 0;
            gap_queue.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_LINE_OFFSET:  offset_q  <= i_cfg_wr_data;
                    REG_SEGMENT_LOW:  seg_lo_q  <= i_cfg_wr_data;
                    REG_SEGMENT_HIGH: seg_hi_q  <= i_cfg_wr_data;
                    REG_AXIS_SELECT:  axis_x    <= i_cfg_wr_data[0];
                    REG_RADIUS_LOW:   band_lo_q <= i_cfg_wr_data[30:0];
                    REG_RADIUS_HIGH:  band_hi_q <= i_cfg_wr_data[30:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                gap_queue.push_back(predict_gap(i_query_radius, i_query_angle,
                                                i_use_lower_crossing));
            if (i_out_valid && i_out_ready) begin
                if (gap_queue.size() == 0) begin
                    $error("unexpected result transfer: gap %0d status %0d",
                           i_angle_gap, i_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = gap_queue.pop_front();
                    if (exp_res.status !== i_status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, i_status);
                        o_fail_count <= o_fail_count + 1;
                    end else if (exp_res.gap !== i_angle_gap) begin
                        $error("angle_gap: expected %0d, got %0d", exp_res.gap, i_angle_gap);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: verif/tb.sv
// Testbench top for the polar angle gap block: stimulus, config phases, verdict.
`timescale 1ns / 1ps
module tb;
    import alpag_pkg::*;

    localparam int LATENCY   = 9 + SQRT_STEPS + CORDIC_ITERATIONS;
    localparam int MAX_CYCLE = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [30:0] q_radius = '0;
    logic [31:0] q_angle = '0;
    logic        q_lower = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [30:0] angle_gap;
    logic [1:0]  status;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int          cycle_count = 0;

    always #5 i_clk = ~i_clk;

    axis_line_polar_angle_gap dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_addr(cfg_addr), .i_cfg_wr_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_query_radius(q_radius), .i_query_angle(q_angle),
        .i_use_lower_crossing(q_lower),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_angle_gap(angle_gap), .o_status(status)
    );

    alpag_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_addr(cfg_addr), .i_cfg_wr_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_query_radius(q_radius), .i_query_angle(q_angle),
        .i_use_lower_crossing(q_lower),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_angle_gap(angle_gap), .i_status(status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_line(input logic [31:0] off, input logic [31:0] lo,
                            input logic [31:0] hi, input logic ax,
                            input logic [30:0] rlo, input logic [30:0] rhi);
        write_reg(REG_LINE_OFFSET, off);
        write_reg(REG_SEGMENT_LOW, lo);
        write_reg(REG_SEGMENT_HIGH, hi);
        write_reg(REG_AXIS_SELECT, {31'd0, ax});
        write_reg(REG_RADIUS_LOW, {1'b0, rlo});
        write_reg(REG_RADIUS_HIGH, {1'b0, rhi});
    endtask

    // one query; valid stays up until the transfer
    task automatic send_query(input logic [30:0] r, input logic [31:0] a, input logic lw);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        q_radius <= r;
        q_angle  <= a;
        q_lower  <= lw;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic logic [30:0] rand_radius(input logic [30:0] off_mag);
        case ($urandom_range(5))
            0: return 31'($urandom());
            1: return 31'($urandom_range(3));
            2: return 31'({1'b0, off_mag} + $urandom_range(255) - 32'd128);
            3: return 31'({1'b0, off_mag} + ($urandom() & 32'h3FFFFF));
            default: return 31'($urandom() & 32'h00FFFFFF);
        endcase
    endfunction

    initial begin
        logic [31:0] off;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mag;
        logic [30:0] rlo;
        logic [30:0] rhi;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero radius and offset, saturation, inverted segment
        set_line(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 31'd0, 31'h7FFF_FFFF);
        send_query(31'd0, 32'h7FFF_FFFF, 1'b1);
        send_query(31'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_query(31'd65536, 32'd0, 1'b1);
        drain();
        for (int ax = 0; ax < 2; ax++) begin
            for (int sg = 0; sg < 2; sg++) begin
                off = sg ? -32'sd196608 : 32'sd196608;
                set_line(off, 32'h8000_0000, 32'h7FFF_FFFF, ax[0], 31'd0, 31'h7FFF_FFFF);
                send_query(31'd0, 32'd12345, 1'b0);
                send_query(31'd65536, 32'd0, 1'b1);
                send_query(31'd327680, 32'h7FFF_FFFF, 1'b1);
                send_query(31'd327680, 32'h8000_0000, 1'b0);
                send_query(31'h7FFF_FFFF, 32'hF000_0000, 1'b0);
                drain();
            end
        end
        set_line(32'd65536, 32'd100, 32'd50, 1'b1, 31'd1000, 31'd500000);
        send_query(31'd999, 32'd1, 1'b0);
        send_query(31'd500001, 32'd1, 1'b1);
        send_query(31'd200000, 32'd1, 1'b1);
        drain();

        // random phases with idling mixes
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            off = $urandom();
            if (ph % 3 == 0) off = $signed(off) >>> 8;
            if (ph == 5) off = 32'h8000_0000;
            if (ph == 6) off = 32'h7FFF_FFFF;
            mag = off[31] ? -off : off;
            lo = $urandom();
            hi = $urandom();
            if (ph % 5 != 4) begin
                lo = -(mag + ($urandom() & 32'hFFFFFF)) >>> ($urandom_range(2));
                hi = (mag + ($urandom() & 32'hFFFFFF)) >>> ($urandom_range(2));
            end
            rlo = (ph % 4 == 1) ? 31'd0 : 31'($urandom_range(mag[30:0] >> 1));
            rhi = (ph % 4 == 2) ? 31'h7FFF_FFFF : 31'(mag[30:0] + ($urandom() & 32'h1FFFFFF));
            set_line(off, lo, hi, ph[0] ^ ph[2], rlo, rhi);
            if (ph == 3) fork
                begin
                    hold_off = 1'b1;
                    repeat (300) @(negedge i_clk);
                    hold_off = 1'b0;
                end
            join_none
            repeat (115) send_query(rand_radius(mag[30:0]), $urandom(),
                                    1'($urandom_range(1)));
            drain();
        end

        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
